@@ rtl/core/he8_pkg.sv @@
package he8_pkg;

  localparam int NumBins   = 256;
  localparam int BinAddrW  = $clog2(NumBins);
  localparam int PixW      = 8;
  localparam int OpW       = 2;
  localparam int CntW      = 23;
  // cumulative sum over all bins, and that sum times 255
  localparam int CumW      = CntW + BinAddrW;
  localparam int NumW      = CumW + PixW;

  localparam int unsigned MaxPixels  = 4194304;
  localparam int unsigned WidthMax   = (2 ** CntW) - 1;
  localparam int unsigned CountLimit = (MaxPixels < WidthMax) ? MaxPixels : WidthMax;

  typedef enum logic [OpW-1:0] {
    OP_CLEAR = 2'd0,
    OP_COUNT = 2'd1,
    OP_BUILD = 2'd2,
    OP_MAP   = 2'd3
  } he8_op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_COUNT,
    ST_MAP,
    ST_BLD_RD,
    ST_BLD_ACC,
    ST_BLD_START,
    ST_BLD_WAIT
  } he8_state_e;

  typedef struct packed {
    logic            start;
    logic [NumW-1:0] num;
    logic [CntW-1:0] den;
  } he8_div_req_t;

endpackage

@@ rtl/core/histogram_equalizer_8bit.sv @@
// Channel   Dir  Signals                          Contents
// s_axis    in   tvalid/tready/tdata/tuser        request: tuser = operation, tdata = pixel
// m_axis    out  tvalid/tready/tdata              result of a map request: equalized level
//
// Clear resets the bin valid bits and the pixel total without leaving idle; count reads
// and writes back one bin; map reads the table, then the output register. Build walks
// all 256 bins, each in order: bin read, accumulate, divider start, range check,
// 8 quotient bits, done flag; a bin whose quotient clamps to 255, or any bin of an
// empty histogram, skips the quotient bits.
// Reset clears the bin valid bits and the pixel total at once; no clearing pass.
// A finished result waits in the output register; requests other than map are still
// taken while it waits, a map request waits until the register frees up.
module histogram_equalizer_8bit import he8_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            s_axis_tvalid,
  output logic            s_axis_tready,
  input  logic [PixW-1:0] s_axis_tdata,   // [7:0] pixel_value
  input  logic [OpW-1:0]  s_axis_tuser,   // [1:0] operation
  output logic            m_axis_tvalid,
  input  logic            m_axis_tready,
  output logic [PixW-1:0] m_axis_tdata    // [7:0] equalized_value
);

  localparam logic [CntW-1:0]     Limit   = CntW'(CountLimit);
  localparam logic [BinAddrW-1:0] LastBin = BinAddrW'(NumBins - 1);

  he8_state_e state_q, state_d;

  logic [BinAddrW-1:0] addr_q;       // bin under count/map, or bin of the build walk
  logic [CumW-1:0]     cum_q;        // running cumulative sum during build
  logic [CntW-1:0]     total_q;
  logic [NumBins-1:0]  valid_q;      // bin written since last clear; else reads as zero
  logic                out_valid_q;
  logic [PixW-1:0]     out_data_q;

  he8_op_e             in_op;
  logic                in_acc;
  logic                out_acc;

  logic                bin_we;
  logic [BinAddrW-1:0] bin_addr;
  logic [CntW-1:0]     bin_rdata;
  logic [CntW-1:0]     bin_val;
  logic [CntW-1:0]     bin_inc;

  logic                tbl_we;
  logic [BinAddrW-1:0] tbl_addr;
  logic [PixW-1:0]     tbl_rdata;

  he8_div_req_t        div_req;
  logic                div_done;
  logic [PixW-1:0]     div_quot;

  assign in_op   = he8_op_e'(s_axis_tuser);
  assign in_acc  = s_axis_tvalid && s_axis_tready;
  assign out_acc = m_axis_tvalid && m_axis_tready;

  assign bin_val = valid_q[addr_q] ? bin_rdata : '0;
  assign bin_inc = (bin_val < Limit) ? bin_val + CntW'(1) : bin_val;

  // ---------------- next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          unique case (in_op)
            OP_CLEAR: state_d = ST_IDLE;
            OP_COUNT: state_d = ST_COUNT;
            OP_BUILD: state_d = ST_BLD_RD;
            OP_MAP:   state_d = ST_MAP;
            default:  state_d = ST_IDLE;
          endcase
        end
      end
      ST_COUNT:     state_d = ST_IDLE;
      ST_MAP:       state_d = ST_IDLE;
      ST_BLD_RD:    state_d = ST_BLD_ACC;
      ST_BLD_ACC:   state_d = ST_BLD_START;
      ST_BLD_START: state_d = ST_BLD_WAIT;
      ST_BLD_WAIT: begin
        if (div_done) begin
          state_d = (addr_q == LastBin) ? ST_IDLE : ST_BLD_RD;
        end
      end
      default:      state_d = ST_IDLE;
    endcase
  end

  // ---------------- outputs of the sequencer
  always_comb begin
    s_axis_tready = 1'b0;
    bin_we        = 1'b0;
    bin_addr      = addr_q;
    tbl_we        = 1'b0;
    tbl_addr      = addr_q;
    div_req.start = 1'b0;
    div_req.num   = {cum_q, {PixW{1'b0}}} - NumW'(cum_q);  // cum * 255
    div_req.den   = total_q;
    unique case (state_q)
      ST_IDLE: begin
        // a map request needs the output register free by the time its data lands
        s_axis_tready = (in_op != OP_MAP) || !out_valid_q || m_axis_tready;
        bin_addr      = s_axis_tdata;
        tbl_addr      = s_axis_tdata;
      end
      ST_COUNT:     bin_we = 1'b1;
      ST_BLD_START: div_req.start = 1'b1;
      ST_BLD_WAIT:  tbl_we = div_done;
      default: begin
      end
    endcase
  end

  // ---------------- control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      total_q     <= '0;
      valid_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (in_acc && (in_op == OP_CLEAR)) begin
        total_q <= '0;
        valid_q <= '0;
      end else if (in_acc && (in_op == OP_COUNT) && (total_q < Limit)) begin
        total_q <= total_q + CntW'(1);
      end
      if (state_q == ST_COUNT) begin
        valid_q[addr_q] <= 1'b1;
      end
      if (state_q == ST_MAP) begin
        out_valid_q <= 1'b1;
      end else if (out_acc) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // ---------------- payload registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      addr_q <= (in_op == OP_BUILD) ? '0 : s_axis_tdata;
      cum_q  <= '0;
    end else if ((state_q == ST_BLD_WAIT) && div_done) begin
      addr_q <= addr_q + BinAddrW'(1);
    end
    if (state_q == ST_BLD_ACC) begin
      cum_q <= cum_q + CumW'(bin_val);
    end
    if (state_q == ST_MAP) begin
      out_data_q <= tbl_rdata;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  he8_ram #(
    .Width(CntW),
    .Depth(NumBins)
  ) u_bins (
    .clk_i  (clk_i),
    .we_i   (bin_we),
    .addr_i (bin_addr),
    .wdata_i(bin_inc),
    .rdata_o(bin_rdata)
  );

  he8_ram #(
    .Width(PixW),
    .Depth(NumBins)
  ) u_table (
    .clk_i  (clk_i),
    .we_i   (tbl_we),
    .addr_i (tbl_addr),
    .wdata_i(div_quot),
    .rdata_o(tbl_rdata)
  );

  he8_div u_div (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (div_req),
    .done_o(div_done),
    .quot_o(div_quot)
  );

  // ---------------- checks
  a_map_slot_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_MAP) |-> !out_valid_q)
    else $error("table data lands while output register is full");

  a_div_done_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == ST_BLD_WAIT))
    else $error("divider finished outside build wait");

  a_total_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    total_q <= Limit)
    else $error("pixel total above count limit");

  a_build_start_next: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_BLD_START) |=> !div_done)
    else $error("divider done one cycle after start");

endmodule

@@ rtl/core/he8_ram.sv @@
module he8_ram #(
  parameter int Width = 8,
  parameter int Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end

endmodule

@@ rtl/core/he8_div.sv @@
// floor(num / den) clamped to 255, zero for den == 0; one quotient bit per cycle
module he8_div import he8_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  he8_div_req_t req_i,
  output logic         done_o,
  output logic [PixW-1:0] quot_o
);

  localparam int StepW = $clog2(PixW + 1);

  logic             busy_q;
  logic [StepW-1:0] step_q;
  logic             done_q;
  logic [NumW-1:0]  rem_q;
  logic [CntW-1:0]  den_q;
  logic [CumW-1:0]  sh_q;
  logic [PixW-1:0]  quot_q;

  logic            den_zero;
  logic            clamp;
  logic            take;
  logic [NumW-1:0] trial;

  assign den_zero = (den_q == '0);
  assign clamp    = (rem_q >= NumW'({den_q, {PixW{1'b0}}}));
  assign take     = (rem_q >= NumW'(sh_q));
  assign trial    = rem_q - NumW'(sh_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        step_q <= '0;
      end else if (busy_q) begin
        if (step_q == '0) begin
          if (den_zero || clamp) begin
            busy_q <= 1'b0;
            done_q <= 1'b1;
          end else begin
            step_q <= StepW'(1);
          end
        end else begin
          if (step_q == StepW'(PixW)) begin
            busy_q <= 1'b0;
            done_q <= 1'b1;
          end
          step_q <= step_q + StepW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q <= req_i.num;
      den_q <= req_i.den;
    end else if (busy_q) begin
      if (step_q == '0) begin
        // range check: anything at or above den*256 saturates
        if (den_zero) begin
          quot_q <= '0;
        end else if (clamp) begin
          quot_q <= '1;
        end else begin
          quot_q <= '0;
        end
        sh_q <= CumW'({den_q, {(PixW-1){1'b0}}});
      end else begin
        if (take) begin
          rem_q <= trial;
        end
        quot_q <= {quot_q[PixW-2:0], take};
        sh_q   <= sh_q >> 1;
      end
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule
